// File: sv/ncdf_pkg.sv
// ----------------------------------------------------------------------------
// ncdf_pkg
// Shared widths, constants and rounding helpers for the normal CDF unit.
// ----------------------------------------------------------------------------
package ncdf_pkg;

    localparam int X_W    = 24;   // signed Q8.16 bound / mean
    localparam int SD_W   = 23;   // unsigned Q7.16 deviation
    localparam int PROB_W = 17;   // Q0.16, 65536 = 1.0
    localparam int C2_W   = 18;   // twice the CDF, Q16
    localparam int Q_W    = 20;   // Horner accumulator, signed
    localparam int T_W    = 17;   // t = 1/(1+p|z|), Q16
    localparam int E_W    = 17;   // exp(-z^2), Q16
    localparam int ZA_W   = 19;   // |z|, Q16, saturated at 4.0

    localparam logic [16:0] Q_ONE   = 17'd65536;
    localparam logic [18:0] Z_MAX   = 19'd262144;
    localparam logic [29:0] K_INV   = 30'd759250125;
    localparam logic [14:0] P_COEF  = 15'd21469;
    localparam logic [16:0] LOG2E   = 17'd94548;
    localparam logic [15:0] LN2     = 16'd45426;
    localparam logic signed [Q_W-1:0] A5_COEF = 20'sd69560;

    function automatic logic signed [Q_W-1:0] horner_add(input logic [2:0] k);
        logic signed [Q_W-1:0] v;
        case (k)
            3'd0:    v = -20'sd95234;
            3'd1:    v = 20'sd93154;
            3'd2:    v = -20'sd18645;
            3'd3:    v = 20'sd16701;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [16:0] pow2_neg(input logic [3:0] i);
        logic [16:0] v;
        case (i)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd62757;
            4'd2:    v = 17'd60097;
            4'd3:    v = 17'd57549;
            4'd4:    v = 17'd55109;
            4'd5:    v = 17'd52773;
            4'd6:    v = 17'd50535;
            4'd7:    v = 17'd48393;
            4'd8:    v = 17'd46341;
            4'd9:    v = 17'd44376;
            4'd10:   v = 17'd42495;
            4'd11:   v = 17'd40693;
            4'd12:   v = 17'd38968;
            4'd13:   v = 17'd37316;
            4'd14:   v = 17'd35734;
            4'd15:   v = 17'd34219;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

    // Q16 product rounding, halves away from zero
    function automatic logic signed [Q_W-1:0] mulq_rnd(input logic signed [37:0] p);
        logic [37:0] mag;
        logic [37:0] r;
        logic signed [Q_W-1:0] res;
        mag = p[37] ? 38'(-p) : 38'(p);
        r   = (mag + 38'd32768) >> 16;
        res = $signed(r[Q_W-1:0]);
        return p[37] ? -res : res;
    endfunction

endpackage

// File: sv/normal_cdf_unit.sv
// ----------------------------------------------------------------------------
// normal_cdf_unit
// Normal-distribution CDF / range probability, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel takes one item per cycle: mean, deviation and bounds in
//   s_tdata, the operation in s_tuser (0 = CDF at upper bound, 1 = mass
//   between lower and upper bound).
//   m_ channel returns one item per input item, in order: the Q0.16
//   probability in m_tdata, the degenerate flag in m_tuser.
//   The pipeline is built from the two bit-per-stage dividers (z-score and
//   reciprocal), the exp chain and the Horner stages. Throughput is one
//   item per cycle while the output is not stalled.
//   When the receiver holds m_tready low with a result pending, the whole
//   pipeline holds and s_tready drops in the same cycle; nothing is lost.
//   Reset (aresetn low, synchronous) empties the pipeline; no warm-up.
//   Zero deviation, or reversed bounds in the range operation, give probability 1.0 with the flag set.
// ----------------------------------------------------------------------------
module normal_cdf_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // upper_bound, lower_bound, mean, std_dev, pad
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // probability, pad
    output logic        m_tuser    // degenerate
);
    import ncdf_pkg::*;

    logic                   en;
    logic signed [X_W-1:0]  upper;
    logic signed [X_W-1:0]  lower;
    logic signed [X_W-1:0]  mean;
    logic [SD_W-1:0]        sd;
    logic                   degen;
    logic                   u_vld;
    logic [C2_W-1:0]        u_c2;
    logic                   u_degen;
    logic                   l_vld;
    logic [C2_W-1:0]        l_c2;
    logic                   l_op;
    logic signed [C2_W:0]   diff;
    logic [C2_W-1:0]        diff_pos;
    logic [C2_W-1:0]        half;
    logic [PROB_W-1:0]      prob_next;
    logic                   m_tvalid_reg;
    logic [PROB_W-1:0]      prob_reg;
    logic                   degen_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    assign upper = s_tdata[23:0];
    assign lower = s_tdata[47:24];
    assign mean  = s_tdata[71:48];
    assign sd    = s_tdata[94:72];
    assign degen = (sd == '0) || (s_tuser && (lower > upper));

    ncdf_cdf2 u_cdf_upper (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (s_tvalid),
        .x       (upper),
        .mean    (mean),
        .sd      (sd),
        .in_sb   (degen),
        .out_vld (u_vld),
        .c2      (u_c2),
        .out_sb  (u_degen)
    );

    ncdf_cdf2 u_cdf_lower (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (s_tvalid),
        .x       (lower),
        .mean    (mean),
        .sd      (sd),
        .in_sb   (s_tuser),
        .out_vld (l_vld),
        .c2      (l_c2),
        .out_sb  (l_op)
    );

    assign diff      = $signed({1'b0, u_c2}) - (l_op ? $signed({1'b0, l_c2}) : '0);
    assign diff_pos  = diff[C2_W] ? '0 : diff[C2_W-1:0];
    assign half      = (diff_pos + 18'd1) >> 1;
    assign prob_next = u_degen ? Q_ONE :
                       (half > 18'(Q_ONE)) ? Q_ONE : half[PROB_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= u_vld && l_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prob_reg  <= prob_next;
            degen_reg <= u_degen;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, prob_reg};
    assign m_tuser  = degen_reg;

endmodule

// File: sv/ncdf_div.sv
// ----------------------------------------------------------------------------
// ncdf_div
// Pipelined restoring divider, one quotient bit per stage, saturating to all
// ones when the quotient does not fit. Carries a sideband with each item.
// ----------------------------------------------------------------------------
module ncdf_div #(
    parameter int NW = 33,
    parameter int DW = 18,
    parameter int QW = 17,
    parameter int SW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_vld,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] in_sb,
    output logic          out_vld,
    output logic [QW-1:0] quot,
    output logic [SW-1:0] out_sb
);
    localparam int CW = ((NW > DW + QW) ? NW : DW + QW) + 1;

    logic [CW-1:0] rem_reg  [0:QW];
    logic [DW-1:0] den_reg  [0:QW];
    logic [QW-1:0] quot_reg [0:QW];
    logic [SW-1:0] sb_reg   [0:QW];
    logic          ovf_reg  [0:QW];
    logic          vld_reg  [0:QW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= CW'(num);
            den_reg[0]  <= den;
            quot_reg[0] <= '0;
            sb_reg[0]   <= in_sb;
            ovf_reg[0]  <= CW'(num) >= (CW'(den) << QW);
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_stage
        logic [CW-1:0] trial;
        logic          fit;

        assign trial = CW'(den_reg[k-1]) << (QW - k);
        assign fit   = rem_reg[k-1] >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= fit ? rem_reg[k-1] - trial : rem_reg[k-1];
                quot_reg[k] <= quot_reg[k-1] | (QW'(fit) << (QW - k));
                den_reg[k]  <= den_reg[k-1];
                sb_reg[k]   <= sb_reg[k-1];
                ovf_reg[k]  <= ovf_reg[k-1];
            end
        end
    end

    assign out_vld = vld_reg[QW];
    assign quot    = ovf_reg[QW] ? '1 : quot_reg[QW];
    assign out_sb  = sb_reg[QW];

endmodule

// File: sv/ncdf_cdf2.sv
// ----------------------------------------------------------------------------
// ncdf_cdf2
// Twice the normal CDF at one point: z-score divide, exp(-z^2), reciprocal
// divide and five-term Horner polynomial, all pipelined.
// ----------------------------------------------------------------------------
module ncdf_cdf2 (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_vld,
    input  logic signed [ncdf_pkg::X_W-1:0] x,
    input  logic signed [ncdf_pkg::X_W-1:0] mean,
    input  logic [ncdf_pkg::SD_W-1:0]      sd,
    input  logic                           in_sb,
    output logic                           out_vld,
    output logic [ncdf_pkg::C2_W-1:0]      c2,
    output logic                           out_sb
);
    import ncdf_pkg::*;

    // stage 1: difference and magnitude
    logic              s1_vld_reg;
    logic              s1_neg_reg;
    logic [24:0]       s1_ad_reg;
    logic [SD_W-1:0]   s1_sd_reg;
    logic              s1_sb_reg;
    logic signed [24:0] d_next;

    assign d_next = 25'(x) - 25'(mean);

    // stage 2: scaled numerator
    logic              s2_vld_reg;
    logic [54:0]       s2_num_reg;
    logic [36:0]       s2_den_reg;
    logic [1:0]        s2_side_reg;

    // z divider
    logic              zd_vld;
    logic [ZA_W-1:0]   zd_q;
    logic [1:0]        zd_side;

    // exp stages
    logic [7:0]        ex_vld_reg;
    logic [ZA_W-1:0]   s3_za_reg, s4_za_reg, s5_za_reg, s6_za_reg, s7_za_reg, s8_za_reg;
    logic [1:0]        s3_sd_reg, s4_sd_reg, s5_sd_reg, s6_sd_reg, s7_sd_reg, s8_sd_reg,
                       s9_sd_reg, s10_sd_reg;
    logic [37:0]       s4_zz_reg;
    logic [37:0]       s5_up_reg;
    logic [4:0]        s6_n_reg, s7_n_reg, s8_n_reg;
    logic [3:0]        s6_i_reg, s7_i_reg;
    logic [27:0]       s6_cp_reg;
    logic [11:0]       s7_c_reg;
    logic [23:0]       s7_cc_reg;
    logic [33:0]       s8_mp_reg;
    logic [E_W-1:0]    s9_e_reg, s10_e_reg;
    logic [33:0]       s9_pz_reg;
    logic [32:0]       s10_num_reg;
    logic [17:0]       s10_den_reg;

    logic [37:0]       w_sum;
    logic [20:0]       w_val;
    logic [37:0]       u_sum;
    logic [20:0]       u_val;
    logic [27:0]       c_sum;
    logic [11:0]       c_val;
    logic [23:0]       cc_sum;
    logic [17:0]       g_val;
    logic [33:0]       m_sum;
    logic [E_W-1:0]    m_val;
    logic [23:0]       e_sum;
    logic [23:0]       e_shift;
    logic [E_W-1:0]    e_val;
    logic [33:0]       pz_sum;
    logic [17:0]       den_val;

    // t divider
    logic              td_vld;
    logic [T_W-1:0]    td_q;
    logic [E_W+1:0]    td_side;

    // Horner stages
    logic signed [Q_W-1:0] hq    [0:5];
    logic signed [37:0]    hp_reg [0:4];
    logic signed [Q_W-1:0] ha_reg [0:4];
    logic [T_W-1:0]        htp_reg [0:4];
    logic [T_W-1:0]        hta_reg [0:4];
    logic [E_W+1:0]        hsp_reg [0:4];
    logic [E_W+1:0]        hsa_reg [0:4];
    logic                  hvp_reg [0:4];
    logic                  hva_reg [0:4];

    // output stages
    logic              f1_vld_reg, f2_vld_reg;
    logic [33:0]       f1_yp_reg;
    logic [1:0]        f1_sd_reg;
    logic [16:0]       qc_val;
    logic [33:0]       ys_sum;
    logic signed [18:0] y_val;
    logic [16:0]       y_clamp;
    logic [C2_W-1:0]   f2_c2_reg;
    logic              f2_sb_reg;

    // ---------------- stage 1, 2 ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg <= in_vld;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_neg_reg  <= d_next[24];
            s1_ad_reg   <= d_next[24] ? 25'(-d_next) : 25'(d_next);
            s1_sd_reg   <= sd;
            s1_sb_reg   <= in_sb;
            s2_num_reg  <= 55'(s1_ad_reg) * 55'(K_INV);
            s2_den_reg  <= {s1_sd_reg, 14'd0};
            s2_side_reg <= {s1_neg_reg, s1_sb_reg};
        end
    end

    ncdf_div #(.NW(55), .DW(37), .QW(ZA_W), .SW(2)) u_zdiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (s2_vld_reg),
        .num     (s2_num_reg),
        .den     (s2_den_reg),
        .in_sb   (s2_side_reg),
        .out_vld (zd_vld),
        .quot    (zd_q),
        .out_sb  (zd_side)
    );

    // ---------------- exp(-z^2) ----------------
    assign w_sum   = s4_zz_reg + 38'd32768;
    assign w_val   = w_sum[36:16];
    assign u_sum   = s5_up_reg + 38'd32768;
    assign u_val   = u_sum[36:16];
    assign c_sum   = s6_cp_reg + 28'd32768;
    assign c_val   = c_sum[27:16];
    assign cc_sum  = s7_cc_reg + 24'd65536;
    assign g_val   = 18'(Q_ONE) - 18'(s7_c_reg) + 18'(cc_sum[23:17]);
    assign m_sum   = s8_mp_reg + 34'd32768;
    assign m_val   = m_sum[32:16];
    assign e_sum   = 24'(m_val) + (24'd1 << (s8_n_reg - 5'd1));
    assign e_shift = e_sum >> s8_n_reg;
    assign e_val   = (s8_n_reg == 5'd0) ? m_val : e_shift[E_W-1:0];
    assign pz_sum  = s9_pz_reg + 34'd32768;
    assign den_val = 18'(Q_ONE) + 18'(pz_sum[32:16]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ex_vld_reg <= '0;
        end else if (en) begin
            ex_vld_reg <= {ex_vld_reg[6:0], zd_vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_za_reg   <= (zd_q > Z_MAX) ? Z_MAX : zd_q;
            s3_sd_reg   <= zd_side;
            s4_zz_reg   <= 38'(s3_za_reg) * 38'(s3_za_reg);
            s4_za_reg   <= s3_za_reg;
            s4_sd_reg   <= s3_sd_reg;
            s5_up_reg   <= 38'(w_val) * 38'(LOG2E);
            s5_za_reg   <= s4_za_reg;
            s5_sd_reg   <= s4_sd_reg;
            s6_n_reg    <= u_val[20:16];
            s6_i_reg    <= u_val[15:12];
            s6_cp_reg   <= 28'(u_val[11:0]) * 28'(LN2);
            s6_za_reg   <= s5_za_reg;
            s6_sd_reg   <= s5_sd_reg;
            s7_c_reg    <= c_val;
            s7_cc_reg   <= 24'(c_val) * 24'(c_val);
            s7_n_reg    <= s6_n_reg;
            s7_i_reg    <= s6_i_reg;
            s7_za_reg   <= s6_za_reg;
            s7_sd_reg   <= s6_sd_reg;
            s8_mp_reg   <= 34'(pow2_neg(s7_i_reg)) * 34'(g_val[16:0]);
            s8_n_reg    <= s7_n_reg;
            s8_za_reg   <= s7_za_reg;
            s8_sd_reg   <= s7_sd_reg;
            s9_e_reg    <= e_val;
            s9_pz_reg   <= 34'(P_COEF) * 34'(s8_za_reg);
            s9_sd_reg   <= s8_sd_reg;
            s10_e_reg   <= s9_e_reg;
            s10_den_reg <= den_val;
            s10_num_reg <= 33'h1_0000_0000 + 33'(den_val[17:1]);
            s10_sd_reg  <= s9_sd_reg;
        end
    end

    ncdf_div #(.NW(33), .DW(18), .QW(T_W), .SW(E_W + 2)) u_tdiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (ex_vld_reg[7]),
        .num     (s10_num_reg),
        .den     (s10_den_reg),
        .in_sb   ({s10_e_reg, s10_sd_reg}),
        .out_vld (td_vld),
        .quot    (td_q),
        .out_sb  (td_side)
    );

    // ---------------- Horner in t ----------------
    assign hq[0] = A5_COEF;

    for (genvar k = 0; k < 5; k++) begin : g_horner
        logic [T_W-1:0] t_in;
        logic [E_W+1:0] s_in;
        logic           v_in;

        if (k == 0) begin : g_first
            assign t_in = td_q;
            assign s_in = td_side;
            assign v_in = td_vld;
        end else begin : g_next
            assign t_in = hta_reg[k-1];
            assign s_in = hsa_reg[k-1];
            assign v_in = hva_reg[k-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                hvp_reg[k] <= 1'b0;
                hva_reg[k] <= 1'b0;
            end else if (en) begin
                hvp_reg[k] <= v_in;
                hva_reg[k] <= hvp_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                hp_reg[k]  <= 38'(hq[k]) * 38'($signed({1'b0, t_in}));
                htp_reg[k] <= t_in;
                hsp_reg[k] <= s_in;
                ha_reg[k]  <= mulq_rnd(hp_reg[k]) + horner_add(3'(k));
                hta_reg[k] <= htp_reg[k];
                hsa_reg[k] <= hsp_reg[k];
            end
        end

        assign hq[k+1] = ha_reg[k];
    end

    // ---------------- erf and output ----------------
    assign qc_val  = hq[5][Q_W-1] ? 17'd0 : hq[5][16:0];
    assign ys_sum  = f1_yp_reg + 34'd32768;
    assign y_val   = 19'sd65536 - $signed({1'b0, ys_sum[33:16]});
    assign y_clamp = y_val[18] ? 17'd0 : (y_val > 19'sd65536) ? Q_ONE : y_val[16:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
        end else if (en) begin
            f1_vld_reg <= hva_reg[4];
            f2_vld_reg <= f1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_yp_reg <= 34'(qc_val) * 34'(hsa_reg[4][E_W+1:2]);
            f1_sd_reg <= hsa_reg[4][1:0];
            f2_c2_reg <= f1_sd_reg[1] ? 18'(Q_ONE) - 18'(y_clamp)
                                      : 18'(Q_ONE) + 18'(y_clamp);
            f2_sb_reg <= f1_sd_reg[0];
        end
    end

    assign out_vld = f2_vld_reg;
    assign c2      = f2_c2_reg;
    assign out_sb  = f2_sb_reg;

endmodule
